@@ design/dtw_pkg.sv @@
// Shared types, constants and calendar helper functions for the date-to-weekday core.
package dtw_pkg;

	// Stream widths: the input item is year, month and day; the result item is gap, flags and weekday
	localparam int unsigned IN_W  = 24;
	localparam int unsigned OUT_W = 32;

	// Field widths
	localparam int unsigned YEAR_W = 14;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned GAP_W  = 22;
	localparam int unsigned WD_W   = 3;

	// Shared multiplier operand and product widths
	localparam int unsigned MUL_A_W = 22;
	localparam int unsigned MUL_B_W = 23;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// Calendar limits and the reference date (January 1 of the reference year)
	localparam int unsigned REF_YEAR = 2000;
	localparam int unsigned MAX_YEAR = 9999;
	localparam int unsigned REF_P    = REF_YEAR - 1;
	localparam int unsigned REF_SERIAL_I =
		REF_P * 365 + REF_P / 4 - REF_P / 100 + REF_P / 400;
	localparam logic [GAP_W-1:0]  REF_SERIAL = GAP_W'(REF_SERIAL_I);
	localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);

	// Reciprocal constants: floor(x/100) = (x*5243)>>19 for x < 2^14,
	// floor(x/7) = (x*4793491)>>25 for x < 2^22
	localparam logic [MUL_B_W-1:0] K_DIV100 = MUL_B_W'(5243);
	localparam int unsigned        SH_DIV100 = 19;
	localparam logic [MUL_B_W-1:0] K_DIV7   = MUL_B_W'(4793491);
	localparam int unsigned        SH_DIV7  = 25;
	localparam logic [MUL_B_W-1:0] K_YEAR   = MUL_B_W'(365);

	// Month codes
	localparam logic [MON_W-1:0] MON_JAN = 4'd1;
	localparam logic [MON_W-1:0] MON_FEB = 4'd2;
	localparam logic [MON_W-1:0] MON_APR = 4'd4;
	localparam logic [MON_W-1:0] MON_JUN = 4'd6;
	localparam logic [MON_W-1:0] MON_SEP = 4'd9;
	localparam logic [MON_W-1:0] MON_NOV = 4'd11;
	localparam logic [MON_W-1:0] MON_DEC = 4'd12;

	// Operand select of the shared multiplier
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DIV100,
		MUL_YEAR,
		MUL_DIV7
	} dtw_mul_sel_t;

	// Command word from the controller to the datapath
	typedef struct packed {
		logic         load;
		dtw_mul_sel_t mul_sel;
		logic         leap_en;
		logic         sum1_en;
		logic         sum2_en;
		logic         gap_en;
		logic         fin_en;
	} dtw_cmd_t;

	// Days in the months before the given month, in a common year
	function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Length of a month
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
	                                               input logic leap);
		logic [DAY_W-1:0] r;
		if (m == MON_FEB) begin
			r = leap ? 5'd29 : 5'd28;
		end else if (m inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}) begin
			r = 5'd30;
		end else begin
			r = 5'd31;
		end
		return r;
	endfunction

endpackage

@@ design/dtw_datapath.sv @@
// Datapath of the date-to-weekday core: shared multiplier, serial day accumulation, result register.
module dtw_datapath
	import dtw_pkg::*;
(
	input  logic             clk,
	input  dtw_cmd_t         cmd,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data
);

	logic [YEAR_W-1:0]  year_q;
	logic [MON_W-1:0]   month_q;
	logic [DAY_W-1:0]   day_q;
	logic [MUL_P_W-1:0] mul_q;
	logic               leap_q;
	logic [7:0]         p100_q;
	logic [GAP_W-1:0]   acc_q;
	logic [GAP_W-1:0]   s_q;
	logic [GAP_W-1:0]   sp1_q;
	logic               ok_q;
	logic [GAP_W-1:0]   gap_q;
	logic               after_q;
	logic [OUT_W-1:0]   out_q;

	logic [YEAR_W-1:0]  p_w;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [7:0]         q100;
	logic [YEAR_W-1:0]  rem_full;
	logic [6:0]         rem100;
	logic               leap_w;
	logic [8:0]         doy;
	logic               ok_w;
	logic [19:0]        q7;
	logic [GAP_W-1:0]   wd_full;

	assign p_w = year_q - YEAR_W'(1);

	// Select operands of the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_DIV100: begin
				mul_a = MUL_A_W'(year_q);
				mul_b = K_DIV100;
			end
			MUL_YEAR: begin
				mul_a = MUL_A_W'(p_w);
				mul_b = K_YEAR;
			end
			MUL_DIV7: begin
				mul_a = sp1_q;
				mul_b = K_DIV7;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Century quotient, remainder and leap rule
	always_comb begin
		q100     = mul_q[SH_DIV100 +: 8];
		rem_full = year_q - {q100, 6'b0} - {1'b0, q100, 5'b0} - {4'b0, q100, 2'b0};
		rem100   = rem_full[6:0];
		leap_w   = ((year_q[1:0] == 2'b00) && (rem100 != 7'd0)) ||
		           ((rem100 == 7'd0) && (q100[1:0] == 2'b00));
	end

	// Day of year and date check
	always_comb begin
		doy  = days_before(month_q) + 9'(day_q) +
		       9'((month_q > MON_FEB) && leap_q);
		ok_w = (year_q != '0) && (year_q <= MAX_YEAR_V) &&
		       (month_q >= MON_JAN) && (month_q <= MON_DEC) &&
		       (day_q != '0) && (day_q <= month_len(month_q, leap_q));
	end

	// Weekday from the quotient by seven
	always_comb begin
		q7      = mul_q[SH_DIV7 +: 20];
		wd_full = sp1_q - GAP_W'({q7, 3'b0} - {3'b0, q7});
	end

	// Step the datapath registers as commanded
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q  <= in_data[YEAR_W-1:0];
			month_q <= in_data[YEAR_W +: MON_W];
			day_q   <= in_data[YEAR_W+MON_W +: DAY_W];
		end
		if (cmd.mul_sel != MUL_NONE) begin
			mul_q <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
		end
		if (cmd.leap_en) begin
			leap_q <= leap_w;
			p100_q <= (rem100 == 7'd0) ? q100 - 8'd1 : q100;
		end
		if (cmd.sum1_en) begin
			acc_q <= mul_q[GAP_W-1:0] + GAP_W'(p_w >> 2) - GAP_W'(p100_q) +
			         GAP_W'(p100_q >> 2);
		end
		if (cmd.sum2_en) begin
			sp1_q <= acc_q + GAP_W'(doy);
			s_q   <= acc_q + GAP_W'(doy) - GAP_W'(1);
			ok_q  <= ok_w;
		end
		if (cmd.gap_en) begin
			after_q <= (s_q >= REF_SERIAL);
			gap_q   <= (s_q >= REF_SERIAL) ? s_q - REF_SERIAL : REF_SERIAL - s_q;
		end
		if (cmd.fin_en) begin
			if (ok_q) begin
				out_q <= {5'b0, 1'b1, wd_full[WD_W-1:0], after_q, gap_q};
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_data = out_q;

endmodule

@@ design/dtw_ctrl.sv @@
// Controller of the date-to-weekday core: step sequencer and output handshake.
module dtw_ctrl
	import dtw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output dtw_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LEAP,
		ST_SUM1,
		ST_SUM2,
		ST_MOD,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the current step
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_NONE;
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_DIV:  cmd.mul_sel = MUL_DIV100;
			ST_LEAP: begin
				cmd.leap_en = 1'b1;
				cmd.mul_sel = MUL_YEAR;
			end
			ST_SUM1: cmd.sum1_en = 1'b1;
			ST_SUM2: cmd.sum2_en = 1'b1;
			ST_MOD: begin
				cmd.gap_en  = 1'b1;
				cmd.mul_sel = MUL_DIV7;
			end
			ST_FIN:  cmd.fin_en = out_free;
			default: cmd = '0;
		endcase
	end

	// Advance the sequence and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_LEAP;
				ST_LEAP: state_q <= ST_SUM1;
				ST_SUM1: state_q <= ST_SUM2;
				ST_SUM2: state_q <= ST_MOD;
				ST_MOD:  state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.fin_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in work");

	a_fin_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_en |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_fin_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_en |=> out_valid_q)
		else $error("finished item not presented");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.leap_en, cmd.sum1_en, cmd.sum2_en, cmd.gap_en,
		          cmd.fin_en}))
		else $error("more than one datapath step in a cycle");

endmodule

@@ design/date_to_weekday_core.sv @@
// Top level of the date-to-weekday core: controller and datapath joined by a command word.
//
// Converts a Gregorian date to its absolute day distance from 2000-01-01, an
// on-or-after flag, the weekday (0 Sunday .. 6 Saturday) and a date-valid flag.
// Slave channel s_*: one item per date. Master channel m_*: one item per date,
// in input order. An invalid year, month or day gives date_ok low and all other
// result fields zero.
// A result appears on m_tvalid after its input item is accepted and has gone
// through the six-step sequence through the single shared multiplier (century
// quotient, year days, weekday quotient) and the adders; the next item is
// accepted only once that sequence has ended. s_tready is high only while
// the sequencer waits for a new item.
// A finished result waits in the output register; the next item is accepted
// and worked on meanwhile, and the sequence holds in its last step until the
// receiver takes the waiting result.
// Reset (arst_n low) empties the sequencer and drops m_tvalid; no item is lost
// after reset because none is held.
module date_to_weekday_core
	import dtw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [13:0] year, [17:14] month, [22:18] day, [23] zero
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [21:0] gap_days, [22] on_or_after, [25:23] weekday,
	                                    // [26] date_ok, [31:27] zero
);

	dtw_cmd_t cmd;

	dtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	dtw_datapath u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule
